[rtl/dtsp_pkg.sv]
// Package with the shared types and constants of the drawing tablet serial port.
package dtsp_pkg;

   // Width of the packed frame latch.
   localparam int unsigned LATCH_W = 19;

   // Request codes.
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // Status codes returned on a read.
   localparam logic [3:0] STATUS_NONE  = 4'd0;
   localparam logic [3:0] STATUS_READY = 4'd4;
   localparam logic [3:0] STATUS_DATA  = 4'd8;

   // Coordinate scaling constants.
   localparam logic [3:0]  X_MUL     = 4'd15;
   localparam logic [8:0]  X_OFFSET  = 9'd8;
   localparam logic [8:0]  Y_RECIP   = 9'd273;
   localparam logic [3:0]  Y_DIV     = 4'd15;
   localparam logic [8:0]  Y_OFFSET  = 9'd14;
   localparam logic [8:0]  COORD_MAX = 9'd255;

   typedef logic [LATCH_W-1:0] latch_type;

   // Control from the item pipeline to the port state.
   typedef struct packed {
      logic       advance;
      logic       is_read;
      logic [1:0] control;
   } step_type;

endpackage

[rtl/dtsp_scale.sv]
// Coordinate scaling and frame packing for a capture write.
module dtsp_scale
   import dtsp_pkg::*;
(
   input  logic [7:0] pointer_x,
   input  logic [7:0] pointer_y,
   input  logic       left_button,
   input  logic       right_button,
   output latch_type  frame
);

   logic [11:0] x_prod;
   logic [8:0]  x_sum;
   logic [7:0]  x_scaled;
   logic [11:0] y_num;
   logic [20:0] y_prod;
   logic [8:0]  y_est;
   logic [11:0] y_rem;
   logic [8:0]  y_quot;
   logic [8:0]  y_diff;
   logic [7:0]  y_scaled;

   // X: floor(x * 15 / 16) + 8, saturated at 255.
   always_comb begin
      x_prod = {4'd0, pointer_x} * {8'd0, X_MUL};
      x_sum  = {1'b0, x_prod[11:4]} + X_OFFSET;
      x_scaled = (x_sum > COORD_MAX) ? COORD_MAX[7:0] : x_sum[7:0];
   end

   // Y: floor(y * 16 / 15) by a reciprocal estimate with one correction step, minus 14, clamped to 0..255.
   always_comb begin
      y_num  = {pointer_y, 4'd0};
      y_prod = {9'd0, y_num} * {12'd0, Y_RECIP};
      y_est  = y_prod[20:12];
      y_rem  = y_num - ({3'd0, y_est} * {8'd0, Y_DIV});
      y_quot = (y_rem >= {8'd0, Y_DIV}) ? y_est + 9'd1 : y_est;
      y_diff = y_quot - Y_OFFSET;
      if (y_quot < Y_OFFSET) begin
         y_scaled = 8'd0;
      end else if (y_diff > COORD_MAX) begin
         y_scaled = COORD_MAX[7:0];
      end else begin
         y_scaled = y_diff[7:0];
      end
   end

   // Pack x, y and the two buttons.
   assign frame = {1'b0, x_scaled, y_scaled, right_button, left_button};

endmodule

[rtl/dtsp_ctrl.sv]
// Port state: shift latch, status and last control bits.
module dtsp_ctrl
   import dtsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  step_type   step,
   input  latch_type  frame,
   output logic [3:0] read_value
);

   latch_type  latch_ff, latch_in;
   logic [3:0] status_ff, status_in;
   logic [1:0] last_ff, last_in;
   latch_type  shifted;

   // Next state for a write item; reads leave the state alone.
   always_comb begin
      latch_in  = latch_ff;
      status_in = status_ff;
      last_in   = last_ff;
      shifted   = (!last_ff[1] && step.control[1]) ?
                  {latch_ff[LATCH_W-2:0], 1'b0} : latch_ff;
      if (step.advance && !step.is_read) begin
         last_in = step.control;
         if (!step.control[0]) begin
            latch_in  = frame;
            status_in = STATUS_NONE;
         end else begin
            latch_in = shifted;
            if (!step.control[1]) begin
               status_in = STATUS_READY;
            end else begin
               status_in = shifted[LATCH_W-1] ? STATUS_NONE : STATUS_DATA;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff  <= '0;
         status_ff <= STATUS_NONE;
         last_ff   <= 2'd0;
      end else begin
         latch_ff  <= latch_in;
         status_ff <= status_in;
         last_ff   <= last_in;
      end
   end

   // A read sees the status only after a write with either control bit set.
   assign read_value = (last_ff != 2'd0) ? status_ff : STATUS_NONE;

endmodule

[rtl/drawing_tablet_serial_port.sv]
// Top level of the drawing tablet serial port: input register, state and result register.
// A read item's result is loaded into the result register as the item leaves the input
// register, and is held there until taken.
// Throughput: one item per cycle; a read item waits in the input register while an
// earlier result is not yet taken.
// Writes give no result and update the port state in the cycle after acceptance.
// Reset (synchronous, active high) clears the latch, status, control bits and valids.
module drawing_tablet_serial_port
   import dtsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   input  logic [7:0] req_write_data,
   input  logic [7:0] req_pointer_x,
   input  logic [7:0] req_pointer_y,
   input  logic       req_left_button,
   input  logic       req_right_button,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_read_bits
);

   logic       in_valid_ff;
   logic       type_ff;
   logic [1:0] control_ff;
   logic [7:0] x_ff, y_ff;
   logic       left_ff, right_ff;
   logic       out_valid_ff, out_valid_in;
   logic [3:0] bits_ff;
   logic       advance;
   logic [3:0] read_value;
   latch_type  frame;
   step_type   step;

   // An item leaves the input register when it is a write or the result slot frees.
   assign advance   = in_valid_ff &&
                      (type_ff == REQ_WRITE || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         type_ff    <= req_type;
         control_ff <= req_write_data[1:0];
         x_ff       <= req_pointer_x;
         y_ff       <= req_pointer_y;
         left_ff    <= req_left_button;
         right_ff   <= req_right_button;
      end
   end

   dtsp_scale u_scale (
      .pointer_x    (x_ff),
      .pointer_y    (y_ff),
      .left_button  (left_ff),
      .right_button (right_ff),
      .frame        (frame)
   );

   assign step = '{advance: advance, is_read: (type_ff == REQ_READ), control: control_ff};

   dtsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .frame      (frame),
      .read_value (read_value)
   );

   // Result register: loaded by a read item, emptied when taken.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      if (advance && type_ff == REQ_READ) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && type_ff == REQ_READ) begin
         bits_ff <= read_value;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_bits = bits_ff;

   // A result only ever carries one of the three status codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (bits_ff == STATUS_NONE || bits_ff == STATUS_READY ||
                        bits_ff == STATUS_DATA))
      else $error("result carries an unknown status code");

   // A held item in the input register is never dropped.
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled item lost from the input register");

   // A write item never fills an empty result register.
   a_write_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (advance && type_ff == REQ_WRITE && !out_valid_ff) |=> !out_valid_ff)
      else $error("write item produced a result");

   // A waiting result that is not taken stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(bits_ff)))
      else $error("waiting result changed");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the drawing tablet serial port: directed table, then random accesses.
module tb_top;
   import dtsp_pkg::*;

   // One port access as the sender presents it, with an optional typed-in result.
   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [7:0] px;
      logic [7:0] py;
      logic       left;
      logic       right;
      logic       typed;
      logic [3:0] want;
   } access_type;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 400;
   localparam int STALL_LIMIT   = 1000;
   localparam int IDLE_PCT      = 38;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_type = REQ_WRITE;
   logic [7:0] req_write_data = 8'h00;
   logic [7:0] req_pointer_x = 8'h00;
   logic [7:0] req_pointer_y = 8'h00;
   logic       req_left_button = 1'b0;
   logic       req_right_button = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_read_bits;

   // Predicted port state.
   latch_type  frame_latch = '0;
   logic [3:0] port_status = STATUS_NONE;
   logic [1:0] last_strobe_bits = 2'b00;

   logic [3:0] read_bits_due [$];
   int         mismatch_count = 0;
   int         items_sent = 0;
   int         quiet_cycles = 0;
   bit         calm = 1'b0;

   // Directed accesses: reset state, coordinate extremes, clock edges and status codes.
   access_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{REQ_READ,  8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, STATUS_NONE},
      '{REQ_WRITE, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0, STATUS_NONE},
      '{REQ_READ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, STATUS_NONE},
      '{REQ_WRITE, 8'h01, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_READ,  8'h00, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1, STATUS_READY},
      '{REQ_WRITE, 8'h03, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_READ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_WRITE, 8'h03, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_READ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_WRITE, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_WRITE, 8'h01, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_READ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, STATUS_READY},
      '{REQ_WRITE, 8'h03, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_READ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_WRITE, 8'hFE, 8'h80, 8'hEF, 1'b1, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_READ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1, STATUS_NONE},
      '{REQ_WRITE, 8'hFD, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_READ,  8'hAA, 8'h55, 8'h55, 1'b1, 1'b0, 1'b1, STATUS_READY},
      '{REQ_WRITE, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_READ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_WRITE, 8'h02, 8'h0E, 8'h0E, 1'b0, 1'b1, 1'b0, STATUS_NONE},
      '{REQ_WRITE, 8'h5A, 8'h7F, 8'hF0, 1'b1, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_WRITE, 8'h01, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_WRITE, 8'h03, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE},
      '{REQ_READ,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_NONE}
   };

   drawing_tablet_serial_port dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_write_data   (req_write_data),
      .req_pointer_x    (req_pointer_x),
      .req_pointer_y    (req_pointer_y),
      .req_left_button  (req_left_button),
      .req_right_button (req_right_button),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_bits    (rsp_read_bits)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Horizontal scaling: fifteen sixteenths plus the offset, saturated.
   function automatic logic [7:0] scaled_x(input logic [7:0] x);
      int v;
      v = int'(x) * int'(X_MUL) / 16 + int'(X_OFFSET);
      if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
      return v[7:0];
   endfunction

   // Vertical scaling: sixteen fifteenths minus the offset, clamped both ways.
   function automatic logic [7:0] scaled_y(input logic [7:0] y);
      int v;
      v = int'(y) * 16 / int'(Y_DIV) - int'(Y_OFFSET);
      if (v < 0) v = 0;
      if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
      return v[7:0];
   endfunction

   // Advances the predicted port state by one access; a read yields its read bits.
   task automatic tablet_port_step(input access_type a, output bit gives,
                                   output logic [3:0] bits);
      gives = 1'b0;
      bits  = STATUS_NONE;
      if (a.kind == REQ_READ) begin
         gives = 1'b1;
         bits  = (last_strobe_bits != 2'b00) ? port_status : STATUS_NONE;
      end else begin
         if (!a.data[0]) begin
            frame_latch = {1'b0, scaled_x(a.px), scaled_y(a.py), a.right, a.left};
            port_status = STATUS_NONE;
         end else begin
            // Only a rising clock bit against the previous write shifts the frame.
            if (!last_strobe_bits[1] && a.data[1]) frame_latch = frame_latch << 1;
            if (!a.data[1]) port_status = STATUS_READY;
            else port_status = frame_latch[LATCH_W-1] ? STATUS_NONE : STATUS_DATA;
         end
         last_strobe_bits = a.data[1:0];
      end
   endtask

   task automatic report_mismatch(input string what, input logic [3:0] got,
                                  input logic [3:0] want);
      $display("mismatch at %0t: %s, got %0d, want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic access_type random_access();
      access_type a;
      a.kind  = 1'($urandom_range(1));
      a.data  = 8'($urandom);
      a.px    = 8'($urandom);
      a.py    = 8'($urandom);
      a.left  = 1'($urandom_range(1));
      a.right = 1'($urandom_range(1));
      a.typed = 1'b0;
      a.want  = STATUS_NONE;
      return a;
   endfunction

   // Presents one item from a falling edge, holds it until accepted, and returns
   // at the next falling edge with valid still high.
   task automatic send_access(input access_type a);
      bit         gives;
      logic [3:0] bits;
      calm = (items_sent >= 150 && items_sent < 230);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= a.kind;
      req_write_data   <= a.data;
      req_pointer_x    <= a.px;
      req_pointer_y    <= a.py;
      req_left_button  <= a.left;
      req_right_button <= a.right;
      do @(posedge clock); while (req_ready !== 1'b1);
      tablet_port_step(a, gives, bits);
      if (gives) read_bits_due.push_back(a.typed ? a.want : bits);
      items_sent++;
      @(negedge clock);
   endtask

   // Lowers valid and holds off until every outstanding read has returned.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (read_bits_due.size() != 0);
   endtask

   // One strobe write with the given clock bit, sometimes followed by a read.
   task automatic send_strobe(input logic clock_bit);
      access_type a;
      a = random_access();
      a.kind    = REQ_WRITE;
      a.data[0] = 1'b1;
      a.data[1] = clock_bit;
      send_access(a);
      if ($urandom_range(1)) begin
         a = random_access();
         a.kind = REQ_READ;
         send_access(a);
      end
   endtask

   // The receiver stalls at random except during the calm stretch.
   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Result checking and the stall watchdog.
   always @(posedge clock) begin
      logic [3:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (read_bits_due.size() == 0) begin
            report_mismatch("result with no read outstanding", rsp_read_bits, STATUS_NONE);
         end else begin
            want = read_bits_due.pop_front();
            if (rsp_read_bits !== want) report_mismatch("read_bits", rsp_read_bits, want);
         end
      end
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   // Stimulus: reset, directed table, then random sequences.
   initial begin
      access_type  a;
      int unsigned shifts;
      int unsigned burst;
      int unsigned pick;
      bit          drained;
      drained = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_access(directed_rows[i]);
      pause_until_drained();

      while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if (!drained && items_sent >= 320) begin
            pause_until_drained();
            drained = 1'b1;
         end
         pick = $urandom_range(9);
         if (pick < 7) begin
            // Well-formed frame: capture, then clock pulses, sometimes past the latch width.
            a = random_access();
            a.kind    = REQ_WRITE;
            a.data[0] = 1'b0;
            send_access(a);
            shifts = $urandom_range(24, 1);
            for (int unsigned s = 0; s < shifts; s++) begin
               send_strobe(1'b0);
               send_strobe(1'b1);
            end
         end else if (pick < 9) begin
            // Noise: arbitrary reads and writes.
            burst = $urandom_range(4, 1);
            for (int unsigned k = 0; k < burst; k++) send_access(random_access());
         end else begin
            // Broken sequence: strobes with random clock bits and no fresh capture.
            burst = $urandom_range(6, 1);
            for (int unsigned k = 0; k < burst; k++) send_strobe(1'($urandom_range(1)));
         end
      end

      pause_until_drained();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && read_bits_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
